// ===== rtl/gbts_pkg.sv =====
// Shared types and constants for the gap buffer text store.
package gbts_pkg;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 11;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;

  typedef struct packed {
    logic load;
    logic ins;
    logic del;
    logic clamp;
    logic rd_left;
    logic rd_shl;
    logic rd_shr;
    logic wr_shl;
    logic wr_shr;
    logic out_load;
  } gbts_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            at_left;
    logic            at_right;
  } gbts_stat_t;

endpackage

// ===== rtl/gbts_if.sv =====
// Valid/ready channel interfaces for edit items and result items.
interface gbts_in_if import gbts_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [CHAR_W-1:0]    ch;
  logic [FIELD_W-1:0]   target_pos;

  modport source (output valid, output op, output ch, output target_pos, input ready);
  modport sink   (input valid, input op, input ch, input target_pos, output ready);
endinterface

interface gbts_out_if import gbts_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [FIELD_W-1:0]   cursor;
  logic [FIELD_W-1:0]   text_length;
  logic                 dropped;
  logic [CHAR_W-1:0]    left_char;
  logic                 left_valid;

  modport source (output valid, output cursor, output text_length, output dropped,
                  output left_char, output left_valid, input ready);
  modport sink   (input valid, input cursor, input text_length, input dropped,
                  input left_char, input left_valid, output ready);
endinterface

// ===== rtl/gap_buffer_text_store.sv =====
// Gap buffer text store: top level joining controller and datapath.
//
// Input channel in_item carries one edit item: op (insert, delete before
// cursor, move cursor, or 3 to just report), ch and target_pos. Result channel
// out_item returns one item per edit: cursor, text_length, dropped (insert
// into a full store), and the byte left of the cursor with its valid flag.
// Items are handled one at a time. Insert, delete and report pass through the
// execute, peek and load states; a move first clamps the target to the text
// length, then shifts the bytes between cursor and target across the gap one
// at a time, each read from the text memory and then written on the other
// side. The next item can be accepted in the cycle after the result is
// loaded into the output register, so a result may still wait there while
// the next edit runs.
// If out_item.ready is low, the finished result holds in the output register
// and the controller waits with the next result until the register is free.
// Synchronous reset empties the text (cursor 0, length 0); memory contents
// are not cleared, as only written bytes are ever read back.
module gap_buffer_text_store import gbts_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  gbts_in_if.sink          in_item,
  gbts_out_if.source       out_item
);

  gbts_cmd_t  cmd;
  gbts_stat_t stat;

  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbts_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_item.op),
    .in_ch           (in_item.ch),
    .in_target_pos   (in_item.target_pos),
    .out_cursor      (out_item.cursor),
    .out_text_length (out_item.text_length),
    .out_dropped     (out_item.dropped),
    .out_left_char   (out_item.left_char),
    .out_left_valid  (out_item.left_valid)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("input accepted again while an item is in flight");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.dropped) |-> (out_item.text_length == FIELD_W'(CAPACITY)))
    else $error("insert dropped while store not full");

  a_left_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && !out_item.left_valid) |-> (out_item.left_char == '0))
    else $error("left byte reported at cursor zero");
`endif

endmodule

// ===== rtl/gbts_datapath.sv =====
// Datapath: gap pointers, text memory, shift moves and result register.
module gbts_datapath import gbts_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gbts_cmd_t          cmd,
  output gbts_stat_t         stat,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CHAR_W-1:0]  in_ch,
  input  logic [FIELD_W-1:0] in_target_pos,
  output logic [FIELD_W-1:0] out_cursor,
  output logic [FIELD_W-1:0] out_text_length,
  output logic               out_dropped,
  output logic [CHAR_W-1:0]  out_left_char,
  output logic               out_left_valid
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (PW > FIELD_W) ? PW : FIELD_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic [CHAR_W-1:0]  mem [CAPACITY];
  logic [PW-1:0]      gf_r, gp_r, tgt_r;
  logic [OP_W-1:0]    op_r;
  logic [CHAR_W-1:0]  ch_r, rdata_r;
  logic [FIELD_W-1:0] tin_r;
  logic               drop_r;

  logic [PW-1:0]      len, gf_dec, gp_dec, gf_inc, gp_inc;
  logic [XW-1:0]      tin_x, len_x;
  logic               full, gf_nz, we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [CHAR_W-1:0]  wdata;

  assign len    = CAP_P - (gp_r - gf_r);
  assign full   = (gf_r == gp_r);
  assign gf_nz  = (gf_r != '0);
  assign gf_dec = gf_r - PW'(1);
  assign gp_dec = gp_r - PW'(1);
  assign gf_inc = gf_r + PW'(1);
  assign gp_inc = gp_r + PW'(1);
  assign tin_x  = XW'(tin_r);
  assign len_x  = XW'(len);

  assign stat.op       = op_r;
  assign stat.at_left  = (tgt_r < gf_r);
  assign stat.at_right = (tgt_r > gf_r);

  assign we    = (cmd.ins && !full) || cmd.wr_shl || cmd.wr_shr;
  assign waddr = cmd.wr_shl ? gp_dec[AW-1:0] : gf_r[AW-1:0];
  assign wdata = cmd.ins ? ch_r : rdata_r;
  assign re    = (cmd.rd_left && gf_nz) || cmd.rd_shl || cmd.rd_shr;
  assign raddr = cmd.rd_shr ? gp_r[AW-1:0] : gf_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gf_r <= '0;
      gp_r <= CAP_P;
    end else begin
      if (cmd.ins && !full) begin
        gf_r <= gf_inc;
      end
      if (cmd.del && gf_nz) begin
        gf_r <= gf_dec;
      end
      if (cmd.wr_shl) begin
        gf_r <= gf_dec;
        gp_r <= gp_dec;
      end
      if (cmd.wr_shr) begin
        gf_r <= gf_inc;
        gp_r <= gp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      ch_r   <= in_ch;
      tin_r  <= in_target_pos;
      drop_r <= 1'b0;
    end
    if (cmd.ins) begin
      drop_r <= full;
    end
    if (cmd.clamp) begin
      tgt_r <= (tin_x > len_x) ? len : PW'(tin_x);
    end
    if (cmd.out_load) begin
      out_cursor      <= FIELD_W'(XW'(gf_r));
      out_text_length <= FIELD_W'(len_x);
      out_dropped     <= drop_r;
      out_left_valid  <= gf_nz;
      out_left_char   <= gf_nz ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gbts_ctrl.sv =====
// Controller: sequences each edit item through the datapath.
module gbts_ctrl import gbts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  gbts_stat_t stat,
  output gbts_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PEEK, S_STEP, S_WR_L, S_WR_R, S_LOAD
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_EXEC: begin
        case (stat.op)
          OP_INSERT: cmd.ins   = 1'b1;
          OP_DELETE: cmd.del   = 1'b1;
          OP_MOVE:   cmd.clamp = 1'b1;
          default:   ;
        endcase
      end
      S_PEEK: cmd.rd_left = 1'b1;
      S_STEP: begin
        if (stat.at_left) begin
          cmd.rd_shl = 1'b1;
        end else if (stat.at_right) begin
          cmd.rd_shr = 1'b1;
        end else begin
          cmd.rd_left = 1'b1;
        end
      end
      S_WR_L: cmd.wr_shl = 1'b1;
      S_WR_R: cmd.wr_shr = 1'b1;
      S_LOAD: cmd.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_EXEC;
        S_EXEC: state_r <= (stat.op == OP_MOVE) ? S_STEP : S_PEEK;
        S_PEEK: state_r <= S_LOAD;
        S_STEP: begin
          if (stat.at_left) begin
            state_r <= S_WR_L;
          end else if (stat.at_right) begin
            state_r <= S_WR_R;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_WR_L: state_r <= S_STEP;
        S_WR_R: state_r <= S_STEP;
        S_LOAD: if (cmd.out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
